### rtl/core/set_assoc_page_cache_lruk_defines.svh
// Assertion macros shared by the page cache RTL.
`ifndef SET_ASSOC_PAGE_CACHE_LRUK_DEFINES_SVH
`define SET_ASSOC_PAGE_CACHE_LRUK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SAPC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SAPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sapc_pkg.sv
package sapc_pkg;

   // Field widths.
   localparam int GFN_W      = 36;
   localparam int PAGE_W     = 40;
   localparam int STAMP_W    = 64;
   localparam int NSETS_W    = 11;
   localparam int GPAGES_W   = 37;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 37;
   localparam int DIV_CNT_W  = 6;

   // Commands.
   localparam logic CMD_INSTALL    = 1'b0;
   localparam logic CMD_MARK_DIRTY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SETS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GUEST_PAGES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UFFD_ATTACHED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RMAP_PRESENT  = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [NSETS_W-1:0]  NUM_SETS_RST    = 11'd1;
   localparam logic [GPAGES_W-1:0] GUEST_PAGES_RST = 37'h10_0000_0000;

   // Sequencer states.
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_RD    = 6'b001000,
      S_EV    = 6'b010000,
      S_WR    = 6'b100000
   } ctl_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load_in;
      logic div_step;
      logic rd_issue;
      logic ev_way;
      logic do_write;
   } ctl_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic clear_done;
      logic oor;
      logic div_done;
      logic last_way;
      logic out_busy;
   } dp_status_type;

endpackage

### rtl/core/sapc_ram.sv
module sapc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sapc_ctl.sv
module sapc_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sapc_pkg::dp_status_type status,
   output sapc_pkg::ctl_cmd_type   cmd
);

   sapc_pkg::ctl_state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sapc_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = sapc_pkg::S_IDLE;
            end
         end
         sapc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = sapc_pkg::S_DIV;
            end
         end
         sapc_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.oor) begin
               state_in = sapc_pkg::S_WR;
            end else if (status.div_done) begin
               state_in = sapc_pkg::S_RD;
            end
         end
         sapc_pkg::S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = sapc_pkg::S_EV;
         end
         sapc_pkg::S_EV: begin
            cmd.ev_way = 1'b1;
            state_in   = status.last_way ? sapc_pkg::S_WR : sapc_pkg::S_RD;
         end
         sapc_pkg::S_WR: begin
            if (!status.out_busy) begin
               cmd.do_write = 1'b1;
               state_in     = sapc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sapc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sapc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/sapc_dp.sv
module sapc_dp #(
   parameter int WAYS      = 8,
   parameter int HISTORY_K = 2,
   parameter int MAX_SETS  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sapc_pkg::ctl_cmd_type                cmd,
   output sapc_pkg::dp_status_type              status,
   input  logic                                req_tuser,
   input  logic [sapc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sapc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   input  logic [sapc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sapc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int GFN_W   = sapc_pkg::GFN_W;
   localparam int PAGE_W  = sapc_pkg::PAGE_W;
   localparam int STAMP_W = sapc_pkg::STAMP_W;
   localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
   localparam int LINES   = MAX_SETS * WAYS;
   localparam int LINE_W  = LINES > 1 ? $clog2(LINES) : 1;
   localparam int SET_W   = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
   localparam int EFF_W   = $clog2(MAX_SETS + 1);
   localparam int TAG_LO  = 2;
   localparam int PAGE_LO = TAG_LO + GFN_W;
   localparam int STP_LO  = PAGE_LO + PAGE_W;
   localparam int ROW_W   = STP_LO + HISTORY_K * STAMP_W;
   localparam int KEY_LO  = STP_LO + (HISTORY_K - 1) * STAMP_W;

   // Configuration registers.
   logic [sapc_pkg::NSETS_W-1:0]  num_sets_ff;
   logic [sapc_pkg::GPAGES_W-1:0] guest_pages_ff;
   logic                          uffd_ff, rmap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_sets_ff    <= sapc_pkg::NUM_SETS_RST;
         guest_pages_ff <= sapc_pkg::GUEST_PAGES_RST;
         uffd_ff        <= 1'b0;
         rmap_ff        <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            sapc_pkg::CSR_NUM_SETS:      num_sets_ff    <= csr_data[sapc_pkg::NSETS_W-1:0];
            sapc_pkg::CSR_GUEST_PAGES:   guest_pages_ff <= csr_data;
            sapc_pkg::CSR_UFFD_ATTACHED: uffd_ff        <= csr_data[0];
            sapc_pkg::CSR_RMAP_PRESENT:  rmap_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Latched request fields.
   logic              cmd_ff, wr_ff, dval_ff;
   logic [GFN_W-1:0]  gfn_ff, gfn_sh_ff;
   logic [PAGE_W-1:0] hpage_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cmd_ff   <= req_tuser;
         gfn_ff   <= req_tdata[GFN_W-1:0];
         hpage_ff <= req_tdata[GFN_W +: PAGE_W];
         wr_ff    <= req_tdata[GFN_W + PAGE_W];
         dval_ff  <= req_tdata[GFN_W + PAGE_W + 1];
      end
   end

   // Range check against the guest page count.
   logic oor;
   assign oor = {1'b0, gfn_ff} >= guest_pages_ff;

   // Effective set count, clamped to one and to the set capacity.
   logic [EFF_W-1:0] eff_sets;
   always_comb begin
      if (num_sets_ff == '0) begin
         eff_sets = EFF_W'(1);
      end else if (32'(num_sets_ff) > 32'(MAX_SETS)) begin
         eff_sets = EFF_W'(MAX_SETS);
      end else begin
         eff_sets = EFF_W'(num_sets_ff);
      end
   end

   // Restoring modulo, one gfn bit per cycle from the top.
   logic [sapc_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [EFF_W-1:0]               rem_ff, rem_in;
   logic [EFF_W:0]                 trial;

   always_comb begin
      trial = {rem_ff, gfn_sh_ff[GFN_W-1]};
      if (trial >= {1'b0, eff_sets}) begin
         rem_in = EFF_W'(trial - {1'b0, eff_sets});
      end else begin
         rem_in = EFF_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         div_cnt_ff <= '0;
         rem_ff     <= '0;
         gfn_sh_ff  <= req_tdata[GFN_W-1:0];
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         rem_ff     <= rem_in;
         gfn_sh_ff  <= {gfn_sh_ff[GFN_W-2:0], 1'b0};
      end
   end

   logic [LINE_W-1:0] line_base;
   assign line_base = LINE_W'(LINE_W'(rem_ff[SET_W-1:0]) * LINE_W'(WAYS));

   // Way scan state.
   logic [WAY_W-1:0]   way_ff, fway_ff, inv_way_ff, best_way_ff;
   logic               found_ff, inv_found_ff;
   logic [STAMP_W-1:0] best_key_ff;
   logic [ROW_W-1:0]   hit_row_ff, best_row_ff;
   logic [ROW_W-1:0]   rd_row;
   logic [STAMP_W-1:0] rd_key;
   logic               rd_hit;

   assign rd_key = rd_row[KEY_LO +: STAMP_W];
   assign rd_hit = rd_row[0] && (rd_row[TAG_LO +: GFN_W] == gfn_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         way_ff       <= '0;
         found_ff     <= 1'b0;
         inv_found_ff <= 1'b0;
      end else if (cmd.ev_way) begin
         way_ff <= way_ff + 1'b1;
         if (rd_hit && !found_ff) begin
            found_ff   <= 1'b1;
            fway_ff    <= way_ff;
            hit_row_ff <= rd_row;
         end
         if (!rd_row[0] && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_way_ff   <= way_ff;
         end
         if (way_ff == '0 || rd_key < best_key_ff) begin
            best_key_ff <= rd_key;
            best_way_ff <= way_ff;
            best_row_ff <= rd_row;
         end
      end
   end

   // Clearing pass over every line after reset.
   logic [LINE_W-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Write-back row, result fields and line update.
   logic [STAMP_W-1:0] clock_ff, clock_next;
   logic [ROW_W-1:0]   new_row;
   logic [WAY_W-1:0]   tgt_way;
   logic               touch;
   logic               r_hit, r_fetch, r_wb, r_disc, r_prot, r_unprot, r_wake, r_rmap;
   logic [GFN_W-1:0]   r_ogfn;
   logic [PAGE_W-1:0]  r_opage;
   logic [sapc_pkg::RSP_DATA_W-1:0] rsp_data_in;

   assign clock_next = clock_ff + 1'b1;
   assign touch      = !oor && (cmd_ff == sapc_pkg::CMD_INSTALL || found_ff);

   always_comb begin
      r_hit    = 1'b0;
      r_fetch  = 1'b0;
      r_wb     = 1'b0;
      r_disc   = 1'b0;
      r_prot   = 1'b0;
      r_unprot = 1'b0;
      r_wake   = 1'b0;
      r_rmap   = 1'b0;
      r_ogfn   = '0;
      r_opage  = '0;
      new_row  = hit_row_ff;
      tgt_way  = fway_ff;
      for (int i = 1; i < HISTORY_K; i++) begin
         new_row[STP_LO + i * STAMP_W +: STAMP_W] =
            hit_row_ff[STP_LO + (i - 1) * STAMP_W +: STAMP_W];
      end
      new_row[STP_LO +: STAMP_W] = clock_next;
      if (cmd_ff == sapc_pkg::CMD_MARK_DIRTY) begin
         r_hit      = found_ff;
         new_row[1] = dval_ff;
         r_rmap     = dval_ff & rmap_ff;
      end else if (found_ff) begin
         r_hit      = 1'b1;
         new_row[1] = hit_row_ff[1] | wr_ff;
         new_row[PAGE_LO +: PAGE_W] = hpage_ff;
         r_rmap     = wr_ff & rmap_ff;
         r_unprot   = wr_ff & uffd_ff;
         r_wake     = uffd_ff;
      end else begin
         // Miss: refill the first invalid way, else the oldest by LRU-K.
         tgt_way = inv_found_ff ? inv_way_ff : best_way_ff;
         if (!inv_found_ff) begin
            r_wb   = best_row_ff[1];
            r_disc = uffd_ff;
            if (r_wb || r_disc) begin
               r_ogfn  = best_row_ff[TAG_LO +: GFN_W];
               r_opage = best_row_ff[PAGE_LO +: PAGE_W];
            end
         end
         new_row    = '0;
         new_row[0] = 1'b1;
         new_row[1] = wr_ff;
         new_row[TAG_LO +: GFN_W]   = gfn_ff;
         new_row[PAGE_LO +: PAGE_W] = hpage_ff;
         new_row[STP_LO +: STAMP_W] = clock_next;
         r_fetch = 1'b1;
         r_prot  = !wr_ff & uffd_ff;
         r_rmap  = wr_ff & rmap_ff;
      end
      if (oor) begin
         rsp_data_in = sapc_pkg::RSP_DATA_W'(1);
      end else begin
         rsp_data_in = {3'b0, r_rmap, r_wake, r_unprot, r_prot, r_disc, r_wb,
                        r_opage, r_ogfn, r_fetch, r_hit, 1'b0};
      end
   end

   // Line memory port selection.
   logic              mem_we;
   logic [LINE_W-1:0] mem_waddr, mem_raddr;
   logic [ROW_W-1:0]  mem_wdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = line_base + LINE_W'(tgt_way);
      mem_wdata = new_row;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.do_write && touch) begin
         mem_we = 1'b1;
      end
   end

   assign mem_raddr = line_base + LINE_W'(way_ff);

   sapc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(LINES)
   ) u_lines (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(rd_row)
   );

   // Access clock and result register.
   logic                            rsp_valid_ff;
   logic [sapc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.do_write && touch) begin
            clock_ff <= clock_next;
         end
         if (cmd.do_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status back to the sequencer.
   assign status.clear_done = clr_ff == LINE_W'(LINES - 1);
   assign status.oor        = oor;
   assign status.div_done   = div_cnt_ff == sapc_pkg::DIV_CNT_W'(GFN_W - 1);
   assign status.last_way   = way_ff == WAY_W'(WAYS - 1);
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

endmodule

### rtl/core/set_assoc_page_cache_lruk.sv
// Channel   Direction  Transfer condition          Content
// req_      in         req_tvalid && req_tready    tuser command, tdata fault fields
// rsp_      out        rsp_tvalid && rsp_tready    tdata result fields
// csr_      in         csr_valid && csr_ready      register index and write data
//
// An in-range item goes from one request transfer to the next through idle, which takes
// the transfer, the bit-serial modulo that picks the set, a line memory read and compare for
// each way, and the line update.
// An out-of-range gfn skips the way scan and the line update. One item is in flight at a time.
// After reset a clearing pass writes every line before req_tready rises.
// A stalled result holds the update until the result register is free.
`include "set_assoc_page_cache_lruk_defines.svh"

module set_assoc_page_cache_lruk #(
   parameter int WAYS      = 8,
   parameter int HISTORY_K = 2,
   parameter int MAX_SETS  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: command
   input  logic                                req_tuser,
   // tdata: gfn[35:0], host_page[75:36], write_fault[76], dirty_value[77]
   input  logic [sapc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: status[0], hit[1], fetch[2], old_gfn[38:3], old_page[78:39], writeback[79],
   // discard[80], protect[81], unprotect[82], wake[83], clear_rmap[84]
   output logic [sapc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sapc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sapc_pkg::CSR_DATA_W-1:0]     csr_data
);

   sapc_pkg::ctl_cmd_type   ctl_cmd;
   sapc_pkg::dp_status_type dp_status;

   assign csr_ready = 1'b1;

   // Sequencer.
   sapc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   // Datapath with the line memory.
   sapc_dp #(
      .WAYS     (WAYS),
      .HISTORY_K(HISTORY_K),
      .MAX_SETS (MAX_SETS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .status    (dp_status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // No request is taken while the clearing pass runs.
   `SAPC_ASSERT_NOW(a_no_req_in_clear, ctl_cmd.clear_step, !req_tready, "request during clear")
   // A new result never overwrites one still waiting.
   `SAPC_ASSERT_NOW(a_no_overwrite, ctl_cmd.do_write, !rsp_tvalid || rsp_tready, "result lost")
   // An accepted request starts the modulo in the next cycle.
   `SAPC_ASSERT_NEXT(a_accept_div, req_tvalid && req_tready, ctl_cmd.div_step, "no modulo step")

endmodule

### tb/sv/set_assoc_page_cache_lruk_tb.sv
`timescale 1ns / 1ps

module set_assoc_page_cache_lruk_tb;

   localparam int NWAYS = 8;
   localparam int NMAX_SETS = 1024;
   localparam int NLINES = NMAX_SETS * NWAYS;
   localparam logic [sapc_pkg::GFN_W-1:0] GFN_ALL_ONES = {sapc_pkg::GFN_W{1'b1}};

   // One result of the block, split into its fields.
   typedef struct {
      logic                        status;
      logic                        hit;
      logic                        fetch;
      logic [sapc_pkg::GFN_W-1:0]  old_gfn;
      logic [sapc_pkg::PAGE_W-1:0] old_page;
      logic                        writeback;
      logic                        discard;
      logic                        protect;
      logic                        unprotect;
      logic                        wake;
      logic                        clear_rmap;
   } fault_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic                            req_tuser;
   logic [sapc_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [sapc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [sapc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sapc_pkg::CSR_DATA_W-1:0] csr_data;

   // Shadow copy of the configuration and of the tag store.
   logic [sapc_pkg::NSETS_W-1:0]  cfg_num_sets;
   logic [sapc_pkg::GPAGES_W-1:0] cfg_guest_pages;
   logic                          cfg_uffd;
   logic                          cfg_rmap;
   logic [sapc_pkg::GFN_W-1:0]    tag_mem [NLINES];
   logic                          valid_mem [NLINES];
   logic                          dirty_mem [NLINES];
   logic [sapc_pkg::PAGE_W-1:0]   page_mem [NLINES];
   logic [63:0]                   stamp_mem [NLINES][2];
   logic [63:0]                   access_count;

   fault_result_type expected_results[$];
   int unsigned      error_count;
   int unsigned      burst_left;
   longint unsigned  gfn_pool[20];

   set_assoc_page_cache_lruk i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int unsigned used_sets();
      if (cfg_num_sets == 0) return 1;
      if (cfg_num_sets > NMAX_SETS) return NMAX_SETS;
      return 32'(cfg_num_sets);
   endfunction

   // Shift the history of one line and stamp it with the next access count.
   task automatic touch_line(input int unsigned ln);
      stamp_mem[ln][1] = stamp_mem[ln][0];
      access_count     = access_count + 64'd1;
      stamp_mem[ln][0] = access_count;
   endtask

   // Update the shadow tag store for one accepted fault and queue its result.
   task automatic predict_fault(input logic cmd, input logic [sapc_pkg::GFN_W-1:0] gfn,
                                input logic [sapc_pkg::PAGE_W-1:0] hpage, input logic wr,
                                input logic dval);
      fault_result_type r;
      int unsigned      base;
      int unsigned      ln;
      int unsigned      victim;
      int               found;
      logic [63:0]      best;
      logic [63:0]      key;
      bit               chose_invalid;
      longint unsigned  g;
      r = '{default: '0};
      found = -1;
      victim = 0;
      chose_invalid = 0;
      g = 64'(gfn);
      if ({1'b0, gfn} >= cfg_guest_pages) begin
         r.status = 1'b1;
         expected_results.push_back(r);
         return;
      end
      base = 32'((g % used_sets()) * NWAYS);
      for (int w = 0; w < NWAYS; w++) begin
         if (found < 0 && valid_mem[base + w] && tag_mem[base + w] == gfn) begin
            found = w;
         end
      end
      if (cmd == sapc_pkg::CMD_MARK_DIRTY) begin
         if (found >= 0) begin
            ln = base + 32'(found);
            r.hit = 1'b1;
            dirty_mem[ln] = dval;
            touch_line(ln);
         end
         r.clear_rmap = dval & cfg_rmap;
      end else if (found >= 0) begin
         ln = base + 32'(found);
         r.hit = 1'b1;
         if (wr) begin
            dirty_mem[ln] = 1'b1;
            r.clear_rmap = cfg_rmap;
         end
         page_mem[ln] = hpage;
         touch_line(ln);
         r.unprotect = wr & cfg_uffd;
         r.wake = cfg_uffd;
      end else begin
         for (int w = 0; w < NWAYS; w++) begin
            if (!chose_invalid && !valid_mem[base + w]) begin
               victim = 32'(w);
               chose_invalid = 1;
            end
         end
         // LRU-2: evict the way whose older stamp is smallest, first way on a tie.
         if (!chose_invalid) begin
            best = stamp_mem[base][1];
            for (int w = 1; w < NWAYS; w++) begin
               key = stamp_mem[base + w][1];
               if (key < best) begin
                  best = key;
                  victim = 32'(w);
               end
            end
         end
         ln = base + victim;
         if (valid_mem[ln]) begin
            r.writeback = dirty_mem[ln];
            r.discard = cfg_uffd;
            if (r.writeback || r.discard) begin
               r.old_gfn = tag_mem[ln];
               r.old_page = page_mem[ln];
            end
         end
         stamp_mem[ln][0] = '0;
         stamp_mem[ln][1] = '0;
         tag_mem[ln] = gfn;
         valid_mem[ln] = 1'b1;
         page_mem[ln] = hpage;
         dirty_mem[ln] = wr;
         r.fetch = 1'b1;
         r.protect = ~wr & cfg_uffd;
         r.clear_rmap = wr & cfg_rmap;
         touch_line(ln);
      end
      expected_results.push_back(r);
   endtask

   // Send one fault; the sender works in bursts separated by random gaps.
   task automatic send_fault(input logic cmd, input logic [sapc_pkg::GFN_W-1:0] gfn,
                             input logic [sapc_pkg::PAGE_W-1:0] hpage, input logic wr,
                             input logic dval);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {2'b00, dval, wr, hpage, gfn};
      do @(posedge clock); while (!req_tready);
      predict_fault(cmd, gfn, hpage, wr, dval);
      burst_left--;
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // One register transfer; only issued while the block is idle.
   task automatic write_csr(input logic [sapc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sapc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sapc_pkg::CSR_NUM_SETS:      cfg_num_sets = value[sapc_pkg::NSETS_W-1:0];
         sapc_pkg::CSR_GUEST_PAGES:   cfg_guest_pages = value[sapc_pkg::GPAGES_W-1:0];
         sapc_pkg::CSR_UFFD_ATTACHED: cfg_uffd = value[0];
         sapc_pkg::CSR_RMAP_PRESENT:  cfg_rmap = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input logic [sapc_pkg::NSETS_W-1:0] sets,
                            input logic [sapc_pkg::GPAGES_W-1:0] gp,
                            input logic uffd, input logic rmap);
      drain();
      write_csr(sapc_pkg::CSR_NUM_SETS, sapc_pkg::CSR_DATA_W'(sets));
      write_csr(sapc_pkg::CSR_GUEST_PAGES, gp);
      write_csr(sapc_pkg::CSR_UFFD_ATTACHED, sapc_pkg::CSR_DATA_W'(uffd));
      write_csr(sapc_pkg::CSR_RMAP_PRESENT, sapc_pkg::CSR_DATA_W'(rmap));
   endtask

   function automatic logic [sapc_pkg::PAGE_W-1:0] rand_page();
      return {8'($urandom_range(0, 255)), 32'($urandom())};
   endfunction

   function automatic logic [sapc_pkg::GFN_W-1:0] rand_gfn();
      return {4'($urandom_range(0, 15)), 32'($urandom())};
   endfunction

   // Fills a single set past its ways, then hits, dirty marks and evictions.
   task automatic test_single_set();
      for (int i = 0; i < 9; i++) begin
         send_fault(sapc_pkg::CMD_INSTALL,
                    (i == 8) ? GFN_ALL_ONES : sapc_pkg::GFN_W'(i * 3),
                    (i == 0) ? {sapc_pkg::PAGE_W{1'b1}} : sapc_pkg::PAGE_W'(i), i[0], 1'b0);
      end
      configure(11'd1, sapc_pkg::GUEST_PAGES_RST, 1'b1, 1'b1);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(6), '0, 1'b1, 1'b1);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(9), rand_page(), 1'b0, 1'b0);
      send_fault(sapc_pkg::CMD_MARK_DIRTY, sapc_pkg::GFN_W'(12), rand_page(), 1'b0, 1'b1);
      send_fault(sapc_pkg::CMD_MARK_DIRTY, sapc_pkg::GFN_W'(15), rand_page(), 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_MARK_DIRTY, sapc_pkg::GFN_W'(1000), rand_page(), 1'b0, 1'b1);
      send_fault(sapc_pkg::CMD_MARK_DIRTY, sapc_pkg::GFN_W'(1001), rand_page(), 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(500), rand_page(), 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(501), rand_page(), 1'b0, 1'b0);
   endtask

   // Out-of-range gfns and the clamped set counts.
   task automatic test_range_and_sets();
      configure(11'd0, 37'd100, 1'b0, 1'b1);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(99), rand_page(), 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(100), rand_page(), 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_MARK_DIRTY, GFN_ALL_ONES, rand_page(), 1'b0, 1'b1);
      configure(11'h7FF, {sapc_pkg::GPAGES_W{1'b1}}, 1'b1, 1'b0);
      send_fault(sapc_pkg::CMD_INSTALL, GFN_ALL_ONES, rand_page(), 1'b0, 1'b0);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(1023), rand_page(), 1'b1, 1'b0);
      configure(11'd1024, sapc_pkg::GUEST_PAGES_RST, 1'b1, 1'b1);
      send_fault(sapc_pkg::CMD_INSTALL, sapc_pkg::GFN_W'(2047), rand_page(), 1'b0, 1'b0);
   endtask

   // Random phases, each with its own configuration and a small pool of
   // gfns crowded into two sets so that hits and evictions are common.
   task automatic test_random_phases();
      int unsigned                   sets;
      longint unsigned               limit;
      longint unsigned               s;
      logic [sapc_pkg::NSETS_W-1:0]  nsets;
      logic [sapc_pkg::GPAGES_W-1:0] gp;
      logic [sapc_pkg::GFN_W-1:0]    gfn;
      int unsigned                   pick;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0: nsets = 11'd0;
            1: nsets = 11'd1;
            2: nsets = 11'h7FF;
            3: nsets = 11'd1024;
            default: nsets = 11'($urandom_range(2, 1023));
         endcase
         case ($urandom_range(0, 3))
            0: gp = {sapc_pkg::GPAGES_W{1'b1}};
            1: gp = sapc_pkg::GUEST_PAGES_RST;
            2: gp = 37'($urandom_range(1, 5000));
            default: gp = {1'b0, rand_gfn()} + 37'd1;
         endcase
         configure(nsets, gp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         sets = used_sets();
         limit = (gp > sapc_pkg::GUEST_PAGES_RST) ? 64'h10_0000_0000 : 64'(gp);
         for (int i = 0; i < 20; i++) begin
            s = (i < 10) ? 64'd0 : 64'(sets / 2);
            if (s >= limit) s = 64'd0;
            gfn_pool[i] = s + sets * (({$urandom(), $urandom()} % ((limit - 1 - s) / sets + 1)));
         end
         for (int i = 0; i < 150; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) gfn = sapc_pkg::GFN_W'(gfn_pool[$urandom_range(0, 19)]);
            else if (pick < 92) gfn = rand_gfn();
            else if (pick < 96) gfn = sapc_pkg::GFN_W'(gp - 37'd1);
            else gfn = sapc_pkg::GFN_W'(gp);
            send_fault(($urandom_range(0, 9) < 7) ? sapc_pkg::CMD_INSTALL
                                                  : sapc_pkg::CMD_MARK_DIRTY,
                       gfn, rand_page(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Receiver stalls on a pattern that periodically switches to a randomly chosen mode.
   initial begin
      int unsigned cyc;
      int unsigned stall_mode;
      cyc = 0;
      stall_mode = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = (cyc % 5 == 0);
            default: rsp_tready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin
      fault_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no fault outstanding");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            check_field("status", 64'(e.status), 64'(rsp_tdata[0]));
            check_field("hit", 64'(e.hit), 64'(rsp_tdata[1]));
            check_field("fetch", 64'(e.fetch), 64'(rsp_tdata[2]));
            check_field("old_gfn", 64'(e.old_gfn), 64'(rsp_tdata[38:3]));
            check_field("old_page", 64'(e.old_page), 64'(rsp_tdata[78:39]));
            check_field("writeback", 64'(e.writeback), 64'(rsp_tdata[79]));
            check_field("discard", 64'(e.discard), 64'(rsp_tdata[80]));
            check_field("protect", 64'(e.protect), 64'(rsp_tdata[81]));
            check_field("unprotect", 64'(e.unprotect), 64'(rsp_tdata[82]));
            check_field("wake", 64'(e.wake), 64'(rsp_tdata[83]));
            check_field("clear_rmap", 64'(e.clear_rmap), 64'(rsp_tdata[84]));
         end
      end
   end

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = sapc_pkg::CMD_INSTALL;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = sapc_pkg::CSR_NUM_SETS;
      csr_data = '0;
      error_count = 0;
      burst_left = 0;
      cfg_num_sets = sapc_pkg::NUM_SETS_RST;
      cfg_guest_pages = sapc_pkg::GUEST_PAGES_RST;
      cfg_uffd = 1'b0;
      cfg_rmap = 1'b0;
      access_count = '0;
      for (int i = 0; i < NLINES; i++) begin
         tag_mem[i] = '0;
         valid_mem[i] = 1'b0;
         dirty_mem[i] = 1'b0;
         page_mem[i] = '0;
         stamp_mem[i][0] = '0;
         stamp_mem[i][1] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_set();
      test_range_and_sets();
      test_random_phases();

      drain();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
